[design/kvls_pkg.sv]
// Shared types, character codes and status codes for the key/value line scanner.
package kvls_pkg;

  localparam int MaxLineDefault = 255;

  localparam logic [7:0] ChrNul   = 8'h00;
  localparam logic [7:0] ChrHash  = 8'h23;
  localparam logic [7:0] ChrColon = 8'h3A;

  localparam logic [1:0] StatusIgnore  = 2'd0;
  localparam logic [1:0] StatusKeyVal  = 2'd1;
  localparam logic [1:0] StatusNoColon = 2'd2;

  typedef struct packed {
    logic       too_long;
    logic [7:0] value_len;
    logic [7:0] value_start;
    logic [7:0] key_len;
    logic [7:0] indent;
    logic [1:0] status;
  } kvls_result_t;

  // Space, form feed, line feed, carriage return, horizontal and vertical tab.
  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h0C) || (c == 8'h0A) || (c == 8'h0D) ||
           (c == 8'h09) || (c == 8'h0B);
  endfunction

endpackage

[design/key_value_line_scanner_top.sv]
// Terminator path: input register, scanner, result register, then out_*.
// Throughput: one input beat per cycle unless stalled; scanner updates per character.
// The only stall is a terminator meeting a full result register that is not being taken.
// Reset (rst_n low at a clock edge, synchronous) empties both registers and returns the
// scanner to the leading-blank phase with every position counter at zero.
module key_value_line_scanner_top
  import kvls_pkg::*;
#(
  parameter int MAX_LINE = MaxLineDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream: one character per beat, tlast marks the terminator beat.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic        in_tlast,   // line_end
  // Result stream: one beat per line.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [1:0] status, [9:2] indent, [17:10] key_len,
                                  // [25:18] value_start, [33:26] value_len, zero pad
  output logic        out_tuser   // too_long
);

  // Input register: holds one accepted beat in front of the scanner.
  logic       in_valid_r;
  logic [7:0] in_char_r;
  logic       in_end_r;

  // Result register: holds a finished result until the downstream side takes it.
  logic         out_valid_r;
  kvls_result_t out_res_r;

  kvls_result_t scan_res;
  logic         out_free;
  logic         step;

  // The result register can be loaded when it is empty or is emptied this cycle.
  assign out_free = !out_valid_r || out_tready;

  // Ordinary characters always advance; a terminator needs room for its result.
  assign step      = in_valid_r && (!in_end_r || out_free);
  assign in_tready = !in_valid_r || step;

  kvls_scan #(
    .MAX_LINE(MAX_LINE)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (step),
    .step_char  (in_char_r),
    .step_end   (in_end_r),
    .result     (scan_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && in_end_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_end_r) begin
      out_res_r <= scan_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_res_r.value_len, out_res_r.value_start,
                       out_res_r.key_len, out_res_r.indent, out_res_r.status};
  assign out_tuser  = out_res_r.too_long;

endmodule

[design/kvls_scan.sv]
// Phase machine and position counters that follow one line, one character a step.
module kvls_scan
  import kvls_pkg::*;
#(
  parameter int MAX_LINE = MaxLineDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step_valid,
  input  logic [7:0]   step_char,
  input  logic         step_end,
  output kvls_result_t result
);

  localparam int PW = $clog2(MAX_LINE + 1);
  localparam logic [PW-1:0] MaxPos = PW'(MAX_LINE);

  localparam logic [2:0] PhLead    = 3'd0;
  localparam logic [2:0] PhKey     = 3'd1;
  localparam logic [2:0] PhVLead   = 3'd2;
  localparam logic [2:0] PhValue   = 3'd3;
  localparam logic [2:0] PhIgnore  = 3'd4;
  localparam logic [2:0] PhNoColon = 3'd5;
  localparam logic [2:0] PhDone    = 3'd6;

  logic [2:0]    phase_r, phase_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] indent_r, indent_nxt;
  logic [PW-1:0] key_end_r, key_end_nxt;
  logic [PW-1:0] val_begin_r, val_begin_nxt;
  logic [PW-1:0] val_end_r, val_end_nxt;
  logic          ovf_r, ovf_nxt;

  logic [PW-1:0] at, fin;
  logic          blank;
  logic [PW-1:0] key_len_w, val_len_w;

  function automatic logic [7:0] clamp8(input logic [PW-1:0] v);
    logic [16:0] vx;
    vx = 17'(v);
    return (vx > 17'd255) ? 8'hFF : vx[7:0];
  endfunction

  assign blank = is_blank(step_char);

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    indent_nxt    = indent_r;
    key_end_nxt   = key_end_r;
    val_begin_nxt = val_begin_r;
    val_end_nxt   = val_end_r;
    ovf_nxt       = ovf_r;
    if (pos_r >= MaxPos) begin
      at  = MaxPos;
      fin = MaxPos;
    end else begin
      at  = pos_r;
      fin = pos_r + PW'(1);
    end
    if (step_valid) begin
      if (step_end) begin
        phase_nxt     = PhLead;
        pos_nxt       = '0;
        indent_nxt    = '0;
        key_end_nxt   = '0;
        val_begin_nxt = '0;
        val_end_nxt   = '0;
        ovf_nxt       = 1'b0;
      end else begin
        if (pos_r >= MaxPos) begin
          ovf_nxt = 1'b1;
        end
        pos_nxt = fin;
        unique case (phase_r)
          PhLead: begin
            if (step_char == ChrNul || step_char == ChrHash) begin
              phase_nxt = PhIgnore;
            end else if (blank) begin
              indent_nxt = fin;
            end else if (step_char == ChrColon) begin
              key_end_nxt   = at;
              val_begin_nxt = fin;
              val_end_nxt   = fin;
              phase_nxt     = PhVLead;
            end else begin
              key_end_nxt = fin;
              phase_nxt   = PhKey;
            end
          end
          PhKey: begin
            if (step_char == ChrNul) begin
              phase_nxt = PhNoColon;
            end else if (step_char == ChrColon) begin
              val_begin_nxt = fin;
              val_end_nxt   = fin;
              phase_nxt     = PhVLead;
            end else if (!blank) begin
              key_end_nxt = fin;
            end
          end
          PhVLead: begin
            if (step_char == ChrNul) begin
              phase_nxt = PhDone;
            end else if (blank) begin
              val_begin_nxt = fin;
              val_end_nxt   = fin;
            end else begin
              val_end_nxt = fin;
              phase_nxt   = PhValue;
            end
          end
          PhValue: begin
            if (step_char == ChrNul) begin
              phase_nxt = PhDone;
            end else if (!blank) begin
              val_end_nxt = fin;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result for a terminator arriving now, taken from the current state.
  assign key_len_w = key_end_r - indent_r;
  assign val_len_w = val_end_r - val_begin_r;

  always_comb begin
    result              = '0;
    result.too_long     = ovf_r;
    if (phase_r == PhLead || phase_r == PhIgnore) begin
      result.status = StatusIgnore;
    end else if (phase_r == PhKey || phase_r == PhNoColon) begin
      result.status = StatusNoColon;
    end else begin
      result.status      = StatusKeyVal;
      result.indent      = clamp8(indent_r);
      result.key_len     = clamp8(key_len_w);
      result.value_start = clamp8(val_begin_r);
      result.value_len   = clamp8(val_len_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PhLead;
      pos_r       <= '0;
      indent_r    <= '0;
      key_end_r   <= '0;
      val_begin_r <= '0;
      val_end_r   <= '0;
      ovf_r       <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      indent_r    <= indent_nxt;
      key_end_r   <= key_end_nxt;
      val_begin_r <= val_begin_nxt;
      val_end_r   <= val_end_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

endmodule
